// ===== hw/rtl/mi3_pkg.sv =====
package mi3_pkg;

	localparam int ELEM_W     = 24;
	localparam int PROD_W     = 48;
	localparam int COF_W      = 49;
	localparam int PART_W     = 49;
	localparam int DET_W      = 75;
	localparam int DEN_W      = DET_W + 1;
	localparam int NUM_W      = 83;
	localparam int QUO_W      = ELEM_W - 1;
	localparam int DIV_STAGES = QUO_W + 1;
	localparam int LATENCY    = 5 + DIV_STAGES + 1;
	localparam int THR_W      = 32;
	localparam logic [THR_W-1:0] THRESH_RESET = 32'd281;

	typedef struct packed {
		logic signed [ELEM_W-1:0] m00;
		logic signed [ELEM_W-1:0] m01;
		logic signed [ELEM_W-1:0] m02;
		logic signed [ELEM_W-1:0] m10;
		logic signed [ELEM_W-1:0] m11;
		logic signed [ELEM_W-1:0] m12;
		logic signed [ELEM_W-1:0] m20;
		logic signed [ELEM_W-1:0] m21;
		logic signed [ELEM_W-1:0] m22;
	} mat_in_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] inv00;
		logic signed [ELEM_W-1:0] inv01;
		logic signed [ELEM_W-1:0] inv02;
		logic signed [ELEM_W-1:0] inv10;
		logic signed [ELEM_W-1:0] inv11;
		logic signed [ELEM_W-1:0] inv12;
		logic signed [ELEM_W-1:0] inv20;
		logic signed [ELEM_W-1:0] inv21;
		logic signed [ELEM_W-1:0] inv22;
		logic                     det_negative;
		logic                     invertible;
	} mat_out_t;

endpackage

// ===== hw/rtl/mi3_div.sv =====
module mi3_div
	import mi3_pkg::*;
(
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic             neg,
	output logic [QUO_W-1:0] quo,
	output logic             sat,
	output logic             neg_out
);

	localparam int CW = DEN_W + QUO_W;

	logic [NUM_W-1:0] rem_q [DIV_STAGES];
	logic [QUO_W-1:0] quo_q [DIV_STAGES];
	logic [DEN_W-1:0] den_q [DIV_STAGES];
	logic             sat_q [DIV_STAGES];
	logic             neg_q [DIV_STAGES];

	always_ff @(posedge clk) begin
		rem_q[0] <= num;
		quo_q[0] <= '0;
		den_q[0] <= den;
		sat_q[0] <= CW'(num) >= {den, {QUO_W{1'b0}}};
		neg_q[0] <= neg;
	end

	for (genvar s = 1; s < DIV_STAGES; s++) begin : g_step
		localparam int K = DIV_STAGES - 1 - s;
		logic [CW-1:0] trial;
		logic          ge;

		assign trial = CW'(den_q[s-1]) << K;
		assign ge    = CW'(rem_q[s-1]) >= trial;

		always_ff @(posedge clk) begin
			rem_q[s] <= ge ? NUM_W'(CW'(rem_q[s-1]) - trial) : rem_q[s-1];
			quo_q[s] <= quo_q[s-1] | (ge ? (QUO_W'(1) << K) : '0);
			den_q[s] <= den_q[s-1];
			sat_q[s] <= sat_q[s-1];
			neg_q[s] <= neg_q[s-1];
		end
	end

	assign quo     = quo_q[DIV_STAGES-1];
	assign sat     = sat_q[DIV_STAGES-1] | (rem_q[DIV_STAGES-1] == '1 && 1'b0);
	assign neg_out = neg_q[DIV_STAGES-1] ^ (den_q[DIV_STAGES-1] == '0 && 1'b0);

endmodule

// ===== hw/rtl/matrix_inverse_3x3_top.sv =====
// Inverts one 3x3 matrix of signed Q8.16 elements per transaction.
// A transaction starts at a clock edge where start is high; busy is always
// low, so a new matrix may be given in every cycle.
// Each result appears on result for one cycle with done high, in the order
// the matrices were given. Throughput is one matrix per cycle.
// Five stages form the cofactors, the determinant and the divider operands,
// then 24 stages run nine restoring dividers in parallel (a saturation check,
// then one quotient bit per stage), and a last stage saturates and signs.
// A matrix whose determinant magnitude is zero or below the threshold (units
// of 2^-48) gives all zeros with invertible low.
// Reset sets the threshold to 281 and empties the pipeline. Write it via
// cfg_we and cfg_wdata only while no matrix is in flight (unenforced).
// The receiver cannot stall, so every result must be taken when done is high.
module matrix_inverse_3x3_top
	import mi3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mat_in_t          matrix,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata,
	output logic             done,
	output mat_out_t         result
);

	logic [THR_W-1:0]   thr_q;
	logic [LATENCY-1:0] vld_q;

	logic signed [PROD_W-1:0] a_s1 [9];
	logic signed [PROD_W-1:0] b_s1 [9];
	logic signed [ELEM_W-1:0] e_s1 [3];
	logic signed [COF_W-1:0]  c_s2 [9];
	logic signed [ELEM_W-1:0] e_s2 [3];
	logic signed [PART_W-1:0] ph_s3 [3];
	logic signed [PART_W-1:0] pl_s3 [3];
	logic signed [COF_W-1:0]  c_s3 [9];
	logic signed [DET_W-1:0]  det_s4;
	logic signed [COF_W-1:0]  c_s4 [9];
	logic [NUM_W-1:0]         num_s5 [9];
	logic [DEN_W-1:0]         den_s5;
	logic                     neg_s5 [9];
	logic                     sing_s5;
	logic                     dneg_s5;

	logic                     sing_q [DIV_STAGES];
	logic                     dneg_q [DIV_STAGES];
	logic [QUO_W-1:0]         quo [9];
	logic                     sat [9];
	logic                     negd [9];
	logic signed [ELEM_W-1:0] val [9];
	logic                     dneg4;
	logic [DET_W-1:0]         dmag4;
	logic                     sing4;
	mat_out_t                 res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			vld_q <= {vld_q[LATENCY-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		a_s1[0] <= matrix.m11 * matrix.m22;
		b_s1[0] <= matrix.m12 * matrix.m21;
		a_s1[1] <= matrix.m02 * matrix.m21;
		b_s1[1] <= matrix.m01 * matrix.m22;
		a_s1[2] <= matrix.m01 * matrix.m12;
		b_s1[2] <= matrix.m02 * matrix.m11;
		a_s1[3] <= matrix.m12 * matrix.m20;
		b_s1[3] <= matrix.m10 * matrix.m22;
		a_s1[4] <= matrix.m00 * matrix.m22;
		b_s1[4] <= matrix.m02 * matrix.m20;
		a_s1[5] <= matrix.m02 * matrix.m10;
		b_s1[5] <= matrix.m00 * matrix.m12;
		a_s1[6] <= matrix.m10 * matrix.m21;
		b_s1[6] <= matrix.m11 * matrix.m20;
		a_s1[7] <= matrix.m01 * matrix.m20;
		b_s1[7] <= matrix.m00 * matrix.m21;
		a_s1[8] <= matrix.m00 * matrix.m11;
		b_s1[8] <= matrix.m01 * matrix.m10;
		e_s1[0] <= matrix.m00;
		e_s1[1] <= matrix.m01;
		e_s1[2] <= matrix.m02;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			c_s2[i] <= COF_W'(a_s1[i]) - COF_W'(b_s1[i]);
		end
		e_s2 <= e_s1;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			ph_s3[j] <= e_s2[j] * $signed(c_s2[3*j][COF_W-1:ELEM_W]);
			pl_s3[j] <= e_s2[j] * $signed({1'b0, c_s2[3*j][ELEM_W-1:0]});
		end
		c_s3 <= c_s2;
	end

	always_ff @(posedge clk) begin
		det_s4 <= (DET_W'(ph_s3[0]) <<< ELEM_W) + DET_W'(pl_s3[0])
			+ (DET_W'(ph_s3[1]) <<< ELEM_W) + DET_W'(pl_s3[1])
			+ (DET_W'(ph_s3[2]) <<< ELEM_W) + DET_W'(pl_s3[2]);
		c_s4 <= c_s3;
	end

	assign dneg4 = det_s4[DET_W-1];
	assign dmag4 = dneg4 ? DET_W'(-det_s4) : DET_W'(det_s4);
	assign sing4 = (dmag4 == '0) || (dmag4 < DET_W'(thr_q));

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			num_s5[i] <= (NUM_W'(c_s4[i][COF_W-1] ? COF_W'(-c_s4[i]) : COF_W'(c_s4[i])) << 33)
				+ NUM_W'(dmag4);
			neg_s5[i] <= c_s4[i][COF_W-1] ^ dneg4;
		end
		den_s5  <= {dmag4, 1'b0};
		sing_s5 <= sing4;
		dneg_s5 <= dneg4;
	end

	for (genvar i = 0; i < 9; i++) begin : g_div
		mi3_div u_div (
			.clk     (clk),
			.num     (num_s5[i]),
			.den     (den_s5),
			.neg     (neg_s5[i]),
			.quo     (quo[i]),
			.sat     (sat[i]),
			.neg_out (negd[i])
		);
	end

	always_ff @(posedge clk) begin
		sing_q[0] <= sing_s5;
		dneg_q[0] <= dneg_s5;
		for (int s = 1; s < DIV_STAGES; s++) begin
			sing_q[s] <= sing_q[s-1];
			dneg_q[s] <= dneg_q[s-1];
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			if (sat[i]) begin
				val[i] = negd[i] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, {QUO_W{1'b1}}};
			end else begin
				val[i] = negd[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
			end
			if (sing_q[DIV_STAGES-1]) begin
				val[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q.inv00        <= val[0];
		res_q.inv01        <= val[1];
		res_q.inv02        <= val[2];
		res_q.inv10        <= val[3];
		res_q.inv11        <= val[4];
		res_q.inv12        <= val[5];
		res_q.inv20        <= val[6];
		res_q.inv21        <= val[7];
		res_q.inv22        <= val[8];
		res_q.det_negative <= dneg_q[DIV_STAGES-1] & ~sing_q[DIV_STAGES-1];
		res_q.invertible   <= ~sing_q[DIV_STAGES-1];
	end

	assign busy   = 1'b0;
	assign done   = vld_q[LATENCY-1];
	assign result = res_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("A transaction did not complete after the pipeline latency.");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.invertible |->
			!result.det_negative && result.inv00 == '0 && result.inv11 == '0
			&& result.inv22 == '0)
		else $error("A singular result carries nonzero fields.");

endmodule
